// ===== rtl/core/ulcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 Latin case converter package
// Shared types, register indexes, reset values and codepoint case functions.
// ----------------------------------------------------------------------------
package ulcc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int BMAP_W     = 256;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CASE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BMAP_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BMAP_1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BMAP_2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BMAP_3    = 3'd4;

    // Tab, newline and space are word boundaries after reset
    localparam logic [CFG_DATA_W-1:0] BMAP_0_RESET = 64'h0000_0001_0000_0600;

    typedef enum logic [1:0] {
        MODE_UPPER = 2'd0,
        MODE_LOWER = 2'd1,
        MODE_CAPS  = 2'd2,
        MODE_PASS  = 2'd3
    } case_mode_t;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } q_entry_t;

    typedef struct packed {
        logic [7:0] held_lead;
        logic       lead_pending;
        logic       word_start;
    } conv_state_t;

    typedef struct packed {
        logic [1:0] count;
        q_entry_t   first;
        q_entry_t   second;
    } conv_result_t;

    function automatic logic [10:0] to_upper_cp(input logic [10:0] cp);
        logic [10:0] r;
        r = cp;
        if (cp >= 11'h0E0 && cp <= 11'h0FE && cp != 11'h0F7) r = cp - 11'h020;
        else if (cp == 11'h0FF)                               r = 11'h178;
        else if (cp >= 11'h101 && cp <= 11'h12F && cp[0])     r = cp - 11'd1;
        else if (cp >= 11'h133 && cp <= 11'h137 && cp[0])     r = cp - 11'd1;
        else if (cp >= 11'h13A && cp <= 11'h148 && !cp[0])    r = cp - 11'd1;
        else if (cp >= 11'h14B && cp <= 11'h177 && cp[0])     r = cp - 11'd1;
        else if (cp >= 11'h17A && cp <= 11'h17E && !cp[0])    r = cp - 11'd1;
        return r;
    endfunction

    function automatic logic [10:0] to_lower_cp(input logic [10:0] cp);
        logic [10:0] r;
        r = cp;
        if (cp >= 11'h0C0 && cp <= 11'h0DE && cp != 11'h0D7) r = cp + 11'h020;
        else if (cp == 11'h178)                               r = 11'h0FF;
        else if (cp >= 11'h100 && cp <= 11'h12E && !cp[0])    r = cp + 11'd1;
        else if (cp >= 11'h132 && cp <= 11'h136 && !cp[0])    r = cp + 11'd1;
        else if (cp >= 11'h139 && cp <= 11'h147 && cp[0])     r = cp + 11'd1;
        else if (cp >= 11'h14A && cp <= 11'h176 && !cp[0])    r = cp + 11'd1;
        else if (cp >= 11'h179 && cp <= 11'h17D && cp[0])     r = cp + 11'd1;
        return r;
    endfunction

endpackage

// ===== rtl/core/ulcc_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Case conversion logic
// Maps one registered byte against the held lead and word state, giving up
// to two result items and the next state.
// ----------------------------------------------------------------------------
module ulcc_conv (
    input  logic [7:0]                  in_byte,
    input  logic                        in_last,
    input  ulcc_pkg::case_mode_t        case_mode,
    input  logic [ulcc_pkg::BMAP_W-1:0] bmap,
    input  ulcc_pkg::conv_state_t       state,
    output ulcc_pkg::conv_state_t       state_next,
    output ulcc_pkg::conv_result_t      result
);
    import ulcc_pkg::*;

    logic        pair_ok;
    logic [10:0] cp;
    logic [10:0] cp_up;
    logic [10:0] cp_lo;
    logic [10:0] cp_map;
    logic        is_lower;
    logic        is_upper;
    logic        is_bound;

    assign pair_ok  = (state.held_lead[7:5] == 3'b110) && (in_byte[7:6] == 2'b10);
    assign cp       = {state.held_lead[4:0], in_byte[5:0]};
    assign cp_up    = to_upper_cp(cp);
    assign cp_lo    = to_lower_cp(cp);
    assign is_lower = in_byte inside {[8'h61:8'h7A]};
    assign is_upper = in_byte inside {[8'h41:8'h5A]};
    assign is_bound = bmap[in_byte];

    always_comb begin
        state_next    = state;
        result.count  = 2'd0;
        result.first  = '{last: in_last, data: in_byte};
        result.second = '{last: in_last, data: in_byte};
        cp_map        = cp;

        if (state.lead_pending) begin
            case (case_mode)
                MODE_UPPER: cp_map = cp_up;
                MODE_LOWER: cp_map = cp_lo;
                MODE_CAPS: begin
                    if (pair_ok && cp_up != cp_lo) begin
                        if (state.word_start) begin
                            cp_map = cp_up;
                            state_next.word_start = 1'b0;
                        end else begin
                            cp_map = cp_lo;
                        end
                    end
                end
                default: cp_map = cp;
            endcase
            result.count       = 2'd2;
            result.first.last  = 1'b0;
            if (pair_ok) begin
                result.first.data  = {3'b110, cp_map[10:6]};
                result.second.data = {2'b10, cp_map[5:0]};
            end else begin
                result.first.data  = state.held_lead;
            end
            state_next.lead_pending = 1'b0;
            state_next.held_lead    = 8'h00;
        end else if (in_byte[7:6] == 2'b11) begin
            // A lead at frame end goes out alone; otherwise hold it
            if (in_last) begin
                result.count = 2'd1;
            end else begin
                state_next.held_lead    = in_byte;
                state_next.lead_pending = 1'b1;
            end
        end else begin
            result.count = 2'd1;
            case (case_mode)
                MODE_UPPER: if (is_lower) result.first.data = in_byte & 8'h5F;
                MODE_LOWER: if (is_upper) result.first.data = in_byte | 8'h60;
                MODE_CAPS: begin
                    if ((is_lower || is_upper) && state.word_start) begin
                        state_next.word_start = 1'b0;
                        result.first.data     = in_byte & 8'h5F;
                    end else if (is_upper) begin
                        result.first.data = in_byte | 8'h60;
                    end else if (is_bound) begin
                        state_next.word_start = 1'b1;
                    end
                end
                default: result.first.data = in_byte;
            endcase
        end

        if (in_last) begin
            state_next.held_lead    = 8'h00;
            state_next.lead_pending = 1'b0;
            state_next.word_start   = 1'b1;
        end
    end

endmodule

// ===== rtl/core/ulcc_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Three-entry shift queue taking up to two items per cycle if room; gives one.
// ----------------------------------------------------------------------------
module ulcc_outq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ulcc_pkg::conv_result_t push_data,
    output logic                   space_ok,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // out_byte[7:0]
    output logic                   m_tlast
);
    import ulcc_pkg::*;

    q_entry_t   q_reg [3];
    q_entry_t   q_next [3];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] base;
    logic [1:0] n_push;
    logic       pop;

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = q_reg[0].data;
    assign m_tlast  = q_reg[0].last;
    assign pop      = m_tvalid && m_tready;
    // Accept only what fits without counting on a pop this cycle
    assign space_ok = ({1'b0, count_reg} + {1'b0, push_data.count}) <= 3'd3;
    assign n_push   = push ? push_data.count : 2'd0;
    assign base     = count_reg - {1'b0, pop};

    always_comb begin
        q_next[0] = pop ? q_reg[1] : q_reg[0];
        q_next[1] = pop ? q_reg[2] : q_reg[1];
        q_next[2] = q_reg[2];
        if (n_push != 2'd0) begin
            case (base)
                2'd0: begin
                    q_next[0] = push_data.first;
                    q_next[1] = push_data.second;
                end
                2'd1: begin
                    q_next[1] = push_data.first;
                    q_next[2] = push_data.second;
                end
                default: q_next[2] = push_data.first;
            endcase
        end
        count_next = base + n_push;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        q_reg <= q_next;
    end

endmodule

// ===== rtl/core/utf8_latin_case_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 Latin case converter
// Streams UTF-8 bytes and converts letter case: upper, lower or capitalize.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries text bytes, s_tlast on the final byte of a frame.
//   m_ channel returns converted bytes in order; m_tlast marks frame end.
//   A lead byte (0xC0..0xFF) gives no output of its own; the byte after it
//   leaves as a two-byte pair. A lead byte with s_tlast leaves alone.
//   Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
//   (0 case_mode, 1..4 boundary maps for bytes 0..255); write only when idle.
// Path: an accepted item passes the input register, then conversion into
//   the result queue, before it shows on m_tvalid.
// Throughput: one input item per cycle while s_tready is high; a pair leaves
//   as its lead and continuation bytes are taken, so a receiver that takes
//   an item every cycle never stalls the input.
// Reset (aresetn low, synchronous): queue empty, no lead held, word start
//   set, case_mode upper, tab/newline/space as word boundaries.
// Stall: the three-entry result queue holds what the receiver leaves;
//   s_tready drops while the waiting item's output would not fit in it.
// ----------------------------------------------------------------------------
module utf8_latin_case_converter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // in_byte[7:0]
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // out_byte[7:0]
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [ulcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ulcc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ulcc_pkg::*;

    logic                             in_valid_reg;
    logic [7:0]                       in_byte_reg;
    logic                             in_last_reg;
    case_mode_t                       mode_reg;
    logic [3:0][CFG_DATA_W-1:0]       bmap_reg;
    conv_state_t                      state_reg;
    conv_state_t                      state_next;
    conv_result_t                     result;
    logic                             space_ok;
    logic                             proc;

    assign proc     = in_valid_reg && space_ok;
    assign s_tready = !in_valid_reg || proc;

    ulcc_conv u_conv (
        .in_byte    (in_byte_reg),
        .in_last    (in_last_reg),
        .case_mode  (mode_reg),
        .bmap       (bmap_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    ulcc_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (proc),
        .push_data (result),
        .space_ok  (space_ok),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{held_lead: 8'h00, lead_pending: 1'b0, word_start: 1'b1};
            mode_reg     <= MODE_UPPER;
            bmap_reg     <= {{3{64'h0}}, BMAP_0_RESET};
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end
            if (proc) begin
                state_reg <= state_next;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CASE_MODE: mode_reg    <= case_mode_t'(cfg_wdata[1:0]);
                    REG_BMAP_0:    bmap_reg[0] <= cfg_wdata;
                    REG_BMAP_1:    bmap_reg[1] <= cfg_wdata;
                    REG_BMAP_2:    bmap_reg[2] <= cfg_wdata;
                    REG_BMAP_3:    bmap_reg[3] <= cfg_wdata;
                    default:       ;
                endcase
            end
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 Latin case converter testbench
// Sends UTF-8 text frames through the s_ stream, predicts every converted
// byte in all case modes and varied boundary map settings, and checks the m_
// stream item by item, with both sides stalling at random in most phases.
// ----------------------------------------------------------------------------
module tb_top;
    import ulcc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 54;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [7:0]            data;
        logic                  last;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wval;
        logic                  typed;
        logic [1:0]            n;
        q_entry_t              r0;
        q_entry_t              r1;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor copy of the block's configuration and state
    case_mode_t            caps_mode;
    logic [CFG_DATA_W-1:0] gap_map [4];
    logic [7:0]            held_byte;
    logic                  lead_held;
    logic                  at_word_start;

    q_entry_t              due_bytes [$];
    dir_row_t              script [$];
    int                    mismatches = 0;
    bit                    idle_on    = 1'b1;
    int                    sink_hold  = 0;

    utf8_latin_case_converter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // in_byte[7:0]
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // out_byte[7:0]
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Codepoints grouped by parity: odd lowers in most runs, even lowers in
    // the odd-upper runs U+0139..U+0148 and U+0179..U+017E
    function automatic logic [10:0] latin_upper(input logic [10:0] cp);
        if (cp >= 11'h0E0 && cp <= 11'h0FE && cp != 11'h0F7) return cp - 11'h020;
        if (cp == 11'h0FF) return 11'h178;
        if (cp[0] && ((cp >= 11'h101 && cp <= 11'h12F) ||
                      (cp >= 11'h133 && cp <= 11'h137) ||
                      (cp >= 11'h14B && cp <= 11'h177)))
            return cp - 11'd1;
        if (!cp[0] && ((cp >= 11'h13A && cp <= 11'h148) ||
                       (cp >= 11'h17A && cp <= 11'h17E)))
            return cp - 11'd1;
        return cp;
    endfunction

    function automatic logic [10:0] latin_lower(input logic [10:0] cp);
        if (cp >= 11'h0C0 && cp <= 11'h0DE && cp != 11'h0D7) return cp + 11'h020;
        if (cp == 11'h178) return 11'h0FF;
        if (!cp[0] && ((cp >= 11'h100 && cp <= 11'h12E) ||
                       (cp >= 11'h132 && cp <= 11'h136) ||
                       (cp >= 11'h14A && cp <= 11'h176)))
            return cp + 11'd1;
        if (cp[0] && ((cp >= 11'h139 && cp <= 11'h147) ||
                      (cp >= 11'h179 && cp <= 11'h17D)))
            return cp + 11'd1;
        return cp;
    endfunction

    task automatic predict_case(input logic [7:0] b, input logic l, output int n,
                                output q_entry_t r0, output q_entry_t r1);
        logic [10:0] cp, up, dn, m;
        logic [7:0]  c;
        logic        lo, hi;
        n  = 0;
        r0 = '0;
        r1 = '0;
        if (lead_held) begin
            r0 = {1'b0, held_byte};
            r1 = {l, b};
            if (held_byte[7:5] == 3'b110 && b[7:6] == 2'b10) begin
                cp = {held_byte[4:0], b[5:0]};
                up = latin_upper(cp);
                dn = latin_lower(cp);
                m  = cp;
                case (caps_mode)
                    MODE_UPPER: m = up;
                    MODE_LOWER: m = dn;
                    MODE_CAPS: begin
                        // letters only; non-letters never look at the map
                        if (up != dn) begin
                            if (at_word_start) begin
                                m = up;
                                at_word_start = 1'b0;
                            end else begin
                                m = dn;
                            end
                        end
                    end
                    default: ;
                endcase
                r0.data = {3'b110, m[10:6]};
                r1.data = {2'b10, m[5:0]};
            end
            n         = 2;
            lead_held = 1'b0;
            held_byte = 8'h00;
        end else if (b[7:6] == 2'b11) begin
            if (l) begin
                r0 = {1'b1, b};
                n  = 1;
            end else begin
                held_byte = b;
                lead_held = 1'b1;
            end
        end else begin
            lo = b >= 8'h61 && b <= 8'h7A;
            hi = b >= 8'h41 && b <= 8'h5A;
            c  = b;
            case (caps_mode)
                MODE_UPPER: if (lo) c = b & 8'h5F;
                MODE_LOWER: if (hi) c = b | 8'h60;
                MODE_CAPS: begin
                    if ((lo || hi) && at_word_start) begin
                        c = b & 8'h5F;
                        at_word_start = 1'b0;
                    end else if (hi) begin
                        c = b | 8'h60;
                    end else if (gap_map[b[7:6]][b[5:0]]) begin
                        at_word_start = 1'b1;
                    end
                end
                default: ;
            endcase
            r0 = {l, c};
            n  = 1;
        end
        if (l) begin
            held_byte     = 8'h00;
            lead_held     = 1'b0;
            at_word_start = 1'b1;
        end
    endtask

    task automatic queue_results(input int n, input q_entry_t r0, input q_entry_t r1);
        if (n > 0) due_bytes.push_back(r0);
        if (n > 1) due_bytes.push_back(r1);
    endtask

    // Returns at the edge that took the item; valid stays high for the next
    task automatic push_byte(input logic [7:0] b, input logic l);
        bit taken;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = (s_tready === 1'b1);
            @(posedge aclk);
        end
    endtask

    // Drain all results, then let the pipeline settle before a write
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (due_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_CASE_MODE)
            caps_mode = case_mode_t'(val[1:0]);
        else if (idx >= REG_BMAP_0 && idx <= REG_BMAP_3)
            gap_map[2'(idx - REG_BMAP_0)] = val;
    endtask

    task automatic run_text(input int count);
        logic [7:0] frame [$];
        logic [7:0] ch;
        int         sent, flen, pick, n;
        q_entry_t   r0, r1;
        sent = 0;
        while (sent < count) begin
            frame.delete();
            flen = $urandom_range(1, 24);
            while (frame.size() < flen) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    ch = 8'h41 + 8'($urandom_range(0, 25));
                    if ($urandom_range(0, 1)) ch = ch | 8'h20;
                    frame.push_back(ch);
                end else if (pick < 55) begin
                    case ($urandom_range(0, 7))
                        0: ch = 8'h20;
                        1: ch = 8'h09;
                        2: ch = 8'h0A;
                        3: ch = 8'h2E;
                        4: ch = 8'h2C;
                        5: ch = 8'h2D;
                        6: ch = 8'h27;
                        default: ch = 8'h5F;
                    endcase
                    frame.push_back(ch);
                end else if (pick < 85) begin
                    // well-formed two-byte sequence in U+0080..U+017F
                    frame.push_back(8'hC2 + 8'($urandom_range(0, 3)));
                    frame.push_back(8'h80 + 8'($urandom_range(0, 63)));
                end else begin
                    frame.push_back(8'($urandom_range(0, 255)));
                end
            end
            foreach (frame[i]) begin
                push_byte(frame[i], i == frame.size() - 1);
                predict_case(frame[i], i == frame.size() - 1, n, r0, r1);
                queue_results(n, r0, r1);
                sent++;
            end
        end
    endtask

    function automatic dir_row_t item_row(input logic [7:0] b, input logic l);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.data = b;
        r.last = l;
        return r;
    endfunction

    function automatic dir_row_t known_row(input logic [7:0] b, input logic l,
                                           input logic [1:0] n,
                                           input logic [7:0] e0, input logic l0,
                                           input logic [7:0] e1, input logic l1);
        dir_row_t r;
        r       = item_row(b, l);
        r.typed = 1'b1;
        r.n     = n;
        r.r0    = {l0, e0};
        r.r1    = {l1, e1};
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.wval = val;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            sink_hold <= $urandom_range(0, 12);
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= 1'b1;
        end
    end

    // Sample at the falling edge: the item leaves at the next rising edge
    always @(negedge aclk) begin : check_out
        q_entry_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (due_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: extra item, expected none, actual data %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = due_bytes.pop_front();
                if (m_tdata !== want.data) begin
                    mismatches++;
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.data, m_tdata);
                end
                if (m_tlast !== want.last) begin
                    mismatches++;
                    $display("%0t: out_last expected %b actual %b",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    initial begin
        dir_row_t              row;
        int                    n, pick;
        q_entry_t              r0, r1;
        case_mode_t            pm;
        logic [CFG_IDX_W-1:0]  ridx;
        logic [CFG_DATA_W-1:0] mv;

        caps_mode     = MODE_UPPER;
        gap_map[0]    = BMAP_0_RESET;
        gap_map[1]    = '0;
        gap_map[2]    = '0;
        gap_map[3]    = '0;
        held_byte     = 8'h00;
        lead_held     = 1'b0;
        at_word_start = 1'b1;

        // Upper case, reset map
        script.push_back(known_row(8'h61, 0, 1, 8'h41, 0, 8'h00, 0));
        script.push_back(known_row(8'h00, 0, 1, 8'h00, 0, 8'h00, 0));
        script.push_back(known_row(8'h80, 0, 1, 8'h80, 0, 8'h00, 0));
        script.push_back(known_row(8'hC3, 0, 0, 8'h00, 0, 8'h00, 0));
        script.push_back(known_row(8'hA9, 0, 2, 8'hC3, 0, 8'h89, 0));
        // y with diaeresis goes up into Latin Extended-A
        script.push_back(known_row(8'hC3, 0, 0, 8'h00, 0, 8'h00, 0));
        script.push_back(known_row(8'hBF, 0, 2, 8'hC5, 0, 8'hB8, 0));
        // broken pair passes as is
        script.push_back(known_row(8'hC3, 0, 0, 8'h00, 0, 8'h00, 0));
        script.push_back(known_row(8'h41, 0, 2, 8'hC3, 0, 8'h41, 0));
        script.push_back(known_row(8'hFF, 0, 0, 8'h00, 0, 8'h00, 0));
        script.push_back(known_row(8'hFF, 0, 2, 8'hFF, 0, 8'hFF, 0));
        // long s has no two-byte partner
        script.push_back(known_row(8'hC5, 0, 0, 8'h00, 0, 8'h00, 0));
        script.push_back(known_row(8'hBF, 0, 2, 8'hC5, 0, 8'hBF, 0));
        script.push_back(known_row(8'hC4, 0, 0, 8'h00, 0, 8'h00, 0));
        script.push_back(known_row(8'h81, 1, 2, 8'hC4, 0, 8'h80, 1));
        // lead byte closing a frame leaves alone
        script.push_back(known_row(8'hC4, 1, 1, 8'hC4, 1, 8'h00, 0));
        script.push_back(cfg_row(REG_CASE_MODE, CFG_DATA_W'(MODE_LOWER)));
        script.push_back(known_row(8'h5A, 0, 1, 8'h7A, 0, 8'h00, 0));
        script.push_back(known_row(8'hC5, 0, 0, 8'h00, 0, 8'h00, 0));
        script.push_back(known_row(8'hB8, 1, 2, 8'hC3, 0, 8'hBF, 1));
        script.push_back(cfg_row(REG_CASE_MODE, CFG_DATA_W'(MODE_CAPS)));
        script.push_back(item_row(8'h68, 0));
        script.push_back(item_row(8'h45, 0));
        script.push_back(item_row(8'h20, 0));
        script.push_back(item_row(8'hC3, 0));
        script.push_back(item_row(8'hA9, 1));
        // pass-through mode with junk above the mode bits; spare indexes ignored
        script.push_back(cfg_row(REG_CASE_MODE, {{(CFG_DATA_W-2){1'b1}}, MODE_PASS}));
        script.push_back(cfg_row(REG_SPARE_LO, 64'h0123_4567_89AB_CDEF));
        script.push_back(known_row(8'h7A, 1, 1, 8'h7A, 1, 8'h00, 0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            row = script[i];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                reg_write(row.idx, row.wval);
            end else begin
                push_byte(row.data, row.last);
                predict_case(row.data, row.last, n, r0, r1);
                if (row.typed)
                    queue_results(row.n, row.r0, row.r1);
                else
                    queue_results(n, r0, r1);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            idle_on = !(phase == 2 || phase >= PHASES - 2);
            wait_idle();
            if (phase < 8)
                pm = case_mode_t'(phase % 4);
            else
                pm = case_mode_t'($urandom_range(0, 3));
            reg_write(REG_CASE_MODE, CFG_DATA_W'(pm));
            for (ridx = REG_BMAP_0; ridx <= REG_BMAP_3; ridx++) begin
                if (phase < 2 || $urandom_range(0, 1)) begin
                    pick = $urandom_range(0, 3);
                    if (phase == 0 || pick == 1)
                        mv = '1;
                    else if (phase == 1 || pick == 0)
                        mv = '0;
                    else if (pick == 2)
                        mv = {$urandom, $urandom};
                    else
                        mv = {$urandom, $urandom} & {$urandom, $urandom};
                    reg_write(ridx, mv);
                end
            end
            if (phase == 5) reg_write(REG_SPARE_HI, {$urandom, $urandom});
            run_text(PHASE_ITEMS);
        end

        s_tvalid <= 1'b0;
        while (due_bytes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && due_bytes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
